/* hdl/chtab_pkg.sv */
package chtab_pkg;

	// fixed field widths
	localparam int KEY_W        = 40;
	localparam int DATA_W       = 32;
	localparam int STATUS_W     = 3;
	localparam int SLOT_W       = 10;
	localparam int TABLE_SIZE_DEF = 1024;

	// home slot is the key modulo this divisor
	localparam int HOME_MOD     = 1000;
	localparam int HOME_W       = 10;

	// key folding: 10-bit chunks weighted by powers of 1024 modulo 1000
	localparam int FOLD_W       = 22;
	localparam int FOLD_R1      = 24;
	localparam int FOLD_R2      = 576;
	localparam int FOLD_R3      = 824;

	// operation codes
	localparam logic KIND_INSERT   = 1'b0;
	localparam logic KIND_WITHDRAW = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_FULL    = 3'd1,
		STAT_WRAP    = 3'd2,
		STAT_EMPTY   = 3'd3,
		STAT_MISSING = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_CHECK,
		S_I_HOME_RD,
		S_I_HOME_EV,
		S_I_TAIL_RD,
		S_I_TAIL_EV,
		S_I_PROBE_RD,
		S_I_PROBE_EV,
		S_I_LINK,
		S_I_STORE,
		S_W_RD,
		S_W_EV,
		S_W_FIX,
		S_W_NXT_RD,
		S_W_COPY,
		S_W_FREE,
		S_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load_in;
		logic    clr_wr;
		logic    mod_step;
		logic    probe_home;
		logic    probe_link;
		logic    probe_inc;
		logic    set_tail;
		logic    wr_new;
		logic    wr_tail_link;
		logic    save_nxt;
		logic    wr_prev_link;
		logic    move_head;
		logic    copy_head;
		logic    free_probe;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    pend_en;
		status_t pend_code;
		logic    out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic kind;
		logic occ;
		logic lnull;
		logic key_match;
		logic steps_lim;
		logic probe_eq_tail;
		logic cnt_full;
		logic cnt_zero;
		logic mod_last;
		logic clr_last;
		logic prev_valid;
		logic out_busy;
	} stat_t;

endpackage

/* hdl/chtab_in_if.sv */
interface chtab_in_if import chtab_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [KEY_W-1:0]  phone_key;
	logic [DATA_W-1:0] record_data;

	modport source (output valid, kind, phone_key, record_data, input ready);
	modport sink (input valid, kind, phone_key, record_data, output ready);
endinterface

/* hdl/chtab_out_if.sv */
interface chtab_out_if import chtab_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;

	modport source (output valid, status, slot, input ready);
	modport sink (input valid, status, slot, output ready);
endinterface

/* hdl/chtab_ctrl.sv */
module chtab_ctrl import chtab_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.pend_code = STAT_OK;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.probe_home = 1'b1;
				if (stat.kind == KIND_INSERT) begin
					if (stat.cnt_full) begin
						cmd.pend_en = 1'b1;
						cmd.pend_code = STAT_FULL;
						state_d = S_RESULT;
					end else begin
						state_d = S_I_HOME_RD;
					end
				end else if (stat.cnt_zero) begin
					cmd.pend_en = 1'b1;
					cmd.pend_code = STAT_EMPTY;
					state_d = S_RESULT;
				end else begin
					state_d = S_W_RD;
				end
			end
			S_I_HOME_RD: state_d = S_I_HOME_EV;
			S_I_HOME_EV, S_I_TAIL_EV: begin
				if (state_q == S_I_HOME_EV && !stat.occ) begin
					state_d = S_I_STORE;
				end else if (!stat.lnull && !stat.steps_lim) begin
					cmd.probe_link = 1'b1;
					state_d = S_I_TAIL_RD;
				end else begin
					cmd.set_tail = 1'b1;
					state_d = S_I_PROBE_RD;
				end
			end
			S_I_TAIL_RD: state_d = S_I_TAIL_EV;
			S_I_PROBE_RD: state_d = S_I_PROBE_EV;
			S_I_PROBE_EV: begin
				if (stat.probe_eq_tail) begin
					cmd.pend_en = 1'b1;
					cmd.pend_code = STAT_WRAP;
					state_d = S_RESULT;
				end else if (stat.occ) begin
					cmd.probe_inc = 1'b1;
					state_d = S_I_PROBE_RD;
				end else begin
					state_d = S_I_LINK;
				end
			end
			S_I_LINK: begin
				cmd.wr_tail_link = 1'b1;
				state_d = S_I_STORE;
			end
			S_I_STORE: begin
				cmd.wr_new  = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.pend_en = 1'b1;
				state_d = S_RESULT;
			end
			S_W_RD: state_d = S_W_EV;
			S_W_EV: begin
				if (stat.key_match) begin
					cmd.save_nxt = 1'b1;
					if (stat.prev_valid) begin
						state_d = S_W_FIX;
					end else if (stat.lnull) begin
						state_d = S_W_FREE;
					end else begin
						cmd.move_head = 1'b1;
						state_d = S_W_NXT_RD;
					end
				end else if (stat.steps_lim || stat.lnull) begin
					cmd.pend_en = 1'b1;
					cmd.pend_code = STAT_MISSING;
					state_d = S_RESULT;
				end else begin
					cmd.probe_link = 1'b1;
					state_d = S_W_RD;
				end
			end
			S_W_FIX: begin
				cmd.wr_prev_link = 1'b1;
				state_d = S_W_FREE;
			end
			S_W_NXT_RD: state_d = S_W_COPY;
			S_W_COPY: begin
				cmd.copy_head = 1'b1;
				state_d = S_W_FREE;
			end
			S_W_FREE: begin
				cmd.free_probe = 1'b1;
				cmd.cnt_dec = 1'b1;
				cmd.pend_en = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && !stat.out_busy) |=> state_q == S_IDLE)
		else $error("result stage did not return to idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("item taken during clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_new, cmd.wr_tail_link, cmd.wr_prev_link, cmd.copy_head,
			cmd.free_probe, cmd.clr_wr}))
		else $error("two table writes in one cycle");

endmodule

/* hdl/chtab_dp.sv */
module chtab_dp import chtab_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic              in_kind,
	input  logic [KEY_W-1:0]  in_key,
	input  logic [DATA_W-1:0] in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic [SLOT_W-1:0] out_slot
);

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int MW = AW + 2;
	localparam int EW = KEY_W + DATA_W;
	localparam int SW = $clog2(TABLE_SIZE + 1);
	localparam int CW = $clog2(TABLE_SIZE);

	// link table entry: occupied, link null, link index
	logic [MW-1:0] meta_mem [TABLE_SIZE];
	logic [EW-1:0] entry_mem [TABLE_SIZE];
	logic [MW-1:0] meta_rd_q;
	logic [EW-1:0] entry_rd_q;

	logic                 kind_q;
	logic [KEY_W-1:0]     key_q;
	logic [DATA_W-1:0]    data_q;
	logic [KEY_W-1:0]     hash_q;
	logic [AW-1:0]        probe_q, tail_q, prev_q, head_q, clr_q, nxt_idx_q;
	logic                 tail_occ_q, prev_occ_q, prev_valid_q, nxt_null_q;
	logic [SW-1:0]        steps_q;
	logic [CW-1:0]        cnt_q;
	logic                 res_valid_q;
	status_t              res_status_q, pend_status_q;
	logic [SLOT_W-1:0]    res_slot_q, pend_slot_q;

	logic [FOLD_W-1:0] fold_sum;
	logic            hash_small, hash_done;
	logic [AW-1:0]   probe_nx;
	logic            meta_we, entry_we;
	logic [AW-1:0]   meta_wa, entry_wa;
	logic [MW-1:0]   meta_wd;
	logic [EW-1:0]   entry_wd;

	// key folding toward the home slot, finished by one compare and subtract
	assign fold_sum = FOLD_W'(hash_q[HOME_W-1:0])
		+ FOLD_W'(hash_q[2*HOME_W-1:HOME_W]) * FOLD_W'(FOLD_R1)
		+ FOLD_W'(hash_q[3*HOME_W-1:2*HOME_W]) * FOLD_W'(FOLD_R2)
		+ FOLD_W'(hash_q[KEY_W-1:3*HOME_W]) * FOLD_W'(FOLD_R3);
	assign hash_small = hash_q[KEY_W-1:HOME_W] == '0;
	assign hash_done  = hash_small && (hash_q[HOME_W-1:0] < HOME_W'(HOME_MOD));
	assign probe_nx = (probe_q == AW'(TABLE_SIZE - 1)) ? '0 : probe_q + 1'b1;

	// status toward the controller
	always_comb begin
		stat.kind          = kind_q;
		stat.occ           = meta_rd_q[AW+1];
		stat.lnull         = meta_rd_q[AW];
		stat.key_match     = meta_rd_q[AW+1] && (entry_rd_q[EW-1:DATA_W] == key_q);
		stat.steps_lim     = steps_q >= SW'(TABLE_SIZE);
		stat.probe_eq_tail = probe_q == tail_q;
		stat.cnt_full      = cnt_q >= CW'(TABLE_SIZE - 1);
		stat.cnt_zero      = cnt_q == '0;
		stat.mod_last      = hash_done;
		stat.clr_last      = clr_q == AW'(TABLE_SIZE - 1);
		stat.prev_valid    = prev_valid_q;
		stat.out_busy      = res_valid_q && !out_ready;
	end

	// table write port selection
	always_comb begin
		meta_we  = 1'b1;
		meta_wa  = probe_q;
		meta_wd  = {1'b0, 1'b1, {AW{1'b0}}};
		entry_we = 1'b0;
		entry_wa = probe_q;
		entry_wd = {key_q, data_q};
		if (cmd.clr_wr) begin
			meta_wa = clr_q;
		end else if (cmd.wr_tail_link) begin
			meta_wa = tail_q;
			meta_wd = {tail_occ_q, 1'b0, probe_q};
		end else if (cmd.wr_new) begin
			meta_wd  = {1'b1, 1'b1, {AW{1'b0}}};
			entry_we = 1'b1;
		end else if (cmd.wr_prev_link) begin
			meta_wa = prev_q;
			meta_wd = {prev_occ_q, nxt_null_q, nxt_idx_q};
		end else if (cmd.copy_head) begin
			meta_wa  = head_q;
			meta_wd  = meta_rd_q;
			entry_we = 1'b1;
			entry_wa = head_q;
			entry_wd = entry_rd_q;
		end else if (!cmd.free_probe) begin
			meta_we = 1'b0;
		end
	end

	// table memories
	always_ff @(posedge clk) begin
		if (meta_we) meta_mem[meta_wa] <= meta_wd;
		meta_rd_q <= meta_mem[probe_q];
	end

	always_ff @(posedge clk) begin
		if (entry_we) entry_mem[entry_wa] <= entry_wd;
		entry_rd_q <= entry_mem[probe_q];
	end

	// item, hash and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= in_kind;
			key_q  <= in_key;
			data_q <= in_data;
			hash_q <= in_key;
		end
		if (cmd.mod_step) begin
			if (!hash_small) begin
				hash_q <= KEY_W'(fold_sum);
			end else if (!hash_done) begin
				hash_q <= KEY_W'(hash_q[HOME_W-1:0] - HOME_W'(HOME_MOD));
			end
		end
		if (cmd.probe_home) begin
			probe_q      <= AW'(hash_q[HOME_W-1:0]);
			steps_q      <= '0;
			prev_valid_q <= 1'b0;
		end
		if (cmd.probe_link) begin
			probe_q      <= meta_rd_q[AW-1:0];
			steps_q      <= steps_q + 1'b1;
			prev_q       <= probe_q;
			prev_occ_q   <= meta_rd_q[AW+1];
			prev_valid_q <= 1'b1;
		end
		if (cmd.probe_inc) probe_q <= probe_nx;
		if (cmd.set_tail) begin
			tail_q     <= probe_q;
			tail_occ_q <= meta_rd_q[AW+1];
			probe_q    <= probe_nx;
		end
		if (cmd.save_nxt) begin
			nxt_null_q <= meta_rd_q[AW];
			nxt_idx_q  <= meta_rd_q[AW-1:0];
		end
		if (cmd.move_head) begin
			head_q  <= probe_q;
			probe_q <= meta_rd_q[AW-1:0];
		end
		if (cmd.pend_en) begin
			pend_status_q <= cmd.pend_code;
			pend_slot_q   <= (cmd.pend_code == STAT_OK) ? probe_q[SLOT_W-1:0] : '0;
		end
		if (cmd.out_load) begin
			res_status_q <= pend_status_q;
			res_slot_q   <= pend_slot_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cmd.cnt_inc) cnt_q <= cnt_q + 1'b1;
			if (cmd.cnt_dec) cnt_q <= cnt_q - 1'b1;
			if (cmd.out_load) res_valid_q <= 1'b1;
			else if (out_ready) res_valid_q <= 1'b0;
		end
	end

	assign out_valid  = res_valid_q;
	assign out_status = res_status_q;
	assign out_slot   = res_slot_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_SIZE - 1))
		else $error("entry count beyond limit");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !stat.cnt_full)
		else $error("insert past full table");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> !stat.cnt_zero)
		else $error("withdraw from empty table");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_status_q != STAT_OK) |-> res_slot_q == '0)
		else $error("slot not zero on refused item");

endmodule

/* hdl/coalesced_hash_table_top.sv */
// Hash table with coalesced chaining, keyed by a decimal phone number.
// req carries one item: kind (insert or withdraw), phone_key, record_data.
// rsp returns exactly one item per request: status and slot.
// Items move on a valid/ready handshake on both channels.
// The home slot is phone_key mod 1000, found by folding the key in 10-bit
// chunks and a final compare and subtract. An item then follows chain links
// and probes slots linearly, each step a read state and an evaluate state,
// then updates the table, on one read and one write port of the table
// memories. A refused item (table full or empty) goes from the check state
// straight to its result; long chains or a crowded table make the walk longer.
// One item is worked on at a time; the next is accepted as soon as the
// result is in the output register, even if rsp has not taken it yet.
// While rsp stalls, a finished result waits and the next item stalls at
// its result stage.
// After reset a clearing pass over the TABLE_SIZE slots marks every slot free
// and every link null; req is not ready during that pass.
module coalesced_hash_table_top import chtab_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input logic        clk,
	input logic        arst_n,
	chtab_in_if.sink   req,
	chtab_out_if.source rsp
);

	cmd_t  cmd;
	stat_t stat;

	chtab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	chtab_dp #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_kind    (req.kind),
		.in_key     (req.phone_key),
		.in_data    (req.record_data),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_status (rsp.status),
		.out_slot   (rsp.slot)
	);

endmodule

/* test/tb_top.sv */
module tb_top import chtab_pkg::*; ();

	localparam int NSLOT    = TABLE_SIZE_DEF;
	localparam int NULL_LNK = -1;

	typedef struct {
		logic              kind;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
		bit                fixed;
		status_t           exp_status;
		logic [SLOT_W-1:0] exp_slot;
	} dir_row_t;

	typedef struct {
		status_t           status;
		logic [SLOT_W-1:0] slot;
	} answer_t;

	logic clk;
	logic arst_n;
	logic hold;

	chtab_in_if  req_if ();
	chtab_out_if rsp_if ();

	coalesced_hash_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// shadow copy of the table
	bit                slot_used [NSLOT];
	int                slot_link [NSLOT];
	logic [KEY_W-1:0]  slot_key  [NSLOT];
	logic [DATA_W-1:0] slot_data [NSLOT];
	int                live_count;

	answer_t          pending_answers[$];
	logic [KEY_W-1:0] live_keys[$];
	int               mismatches;
	int               sent_items;
	int               burst_left;
	int               stall_mode;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard limit on run length
	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// table model: works out status and slot of one item, updates the shadow
	function automatic answer_t table_apply(logic kind, logic [KEY_W-1:0] key,
			logic [DATA_W-1:0] data);
		answer_t a;
		int      p;
		int      tail;
		int      prv;
		int      nxt;
		int      steps;
		a.status = STAT_OK;
		a.slot   = '0;
		p        = int'(64'(key) % 64'd1000);
		if (kind == KIND_INSERT) begin
			if (live_count >= NSLOT - 1) begin
				a.status = STAT_FULL;
				return a;
			end
			if (slot_used[p]) begin
				steps = 0;
				while (slot_link[p] != NULL_LNK && steps < NSLOT) begin
					p = slot_link[p];
					steps++;
				end
				tail = p;
				p    = (p + 1) % NSLOT;
				while (slot_used[p] && p != tail)
					p = (p + 1) % NSLOT;
				if (p == tail) begin
					a.status = STAT_WRAP;
					return a;
				end
				slot_link[tail] = p;
			end
			slot_used[p] = 1'b1;
			slot_key[p]  = key;
			slot_data[p] = data;
			slot_link[p] = NULL_LNK;
			live_count++;
			a.slot = p[SLOT_W-1:0];
			return a;
		end
		if (live_count == 0) begin
			a.status = STAT_EMPTY;
			return a;
		end
		prv   = NULL_LNK;
		steps = 0;
		while (p != NULL_LNK && !(slot_used[p] && slot_key[p] == key)) begin
			steps++;
			if (steps > NSLOT) begin
				a.status = STAT_MISSING;
				return a;
			end
			prv = p;
			p   = slot_link[p];
		end
		if (p == NULL_LNK) begin
			a.status = STAT_MISSING;
			return a;
		end
		nxt = slot_link[p];
		if (prv != NULL_LNK) begin
			slot_link[prv] = nxt;
			slot_used[p]   = 1'b0;
			slot_link[p]   = NULL_LNK;
			a.slot         = p[SLOT_W-1:0];
		end else if (nxt == NULL_LNK) begin
			slot_used[p] = 1'b0;
			a.slot       = p[SLOT_W-1:0];
		end else begin
			// head refilled from its successor
			slot_used[p]   = slot_used[nxt];
			slot_key[p]    = slot_key[nxt];
			slot_data[p]   = slot_data[nxt];
			slot_link[p]   = slot_link[nxt];
			slot_used[nxt] = 1'b0;
			slot_link[nxt] = NULL_LNK;
			a.slot         = nxt[SLOT_W-1:0];
		end
		live_count--;
		return a;
	endfunction

	function automatic logic [KEY_W-1:0] phone_of(int home);
		logic [63:0] hi;
		hi = 64'($urandom_range(0, 999999999));
		return KEY_W'(hi * 64'd1000 + 64'(home));
	endfunction

	// offer one item, wait for acceptance, record what must come back
	task automatic offer(logic kind, logic [KEY_W-1:0] key, logic [DATA_W-1:0] data,
			bit fixed, status_t fx_status, logic [SLOT_W-1:0] fx_slot);
		answer_t a;
		int      i;
		int      gap;
		req_if.valid       <= 1'b1;
		req_if.kind        <= kind;
		req_if.phone_key   <= key;
		req_if.record_data <= data;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		a = table_apply(kind, key, data);
		if (a.status == STAT_OK) begin
			if (kind == KIND_INSERT)
				live_keys.push_back(key);
			else begin
				for (i = 0; i < live_keys.size(); i++)
					if (live_keys[i] == key) begin
						live_keys.delete(i);
						break;
					end
			end
		end
		if (fixed) begin
			a.status = fx_status;
			a.slot   = fx_slot;
		end
		pending_answers.push_back(a);
		sent_items++;
		// bursts with random gaps
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
	endtask

	task automatic offer_mixed(int n);
		int               k;
		logic [KEY_W-1:0] key;
		logic             kind;
		for (k = 0; k < n; k++) begin
			kind = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0: key = KEY_W'({$urandom, $urandom});
				1, 2, 3: begin
					if (live_keys.size() > 0)
						key = live_keys[$urandom_range(0, live_keys.size() - 1)];
					else
						key = phone_of($urandom_range(0, 999));
				end
				default: key = phone_of($urandom_range(0, 15) * 7);
			endcase
			offer(kind, key, $urandom, 1'b0, STAT_OK, '0);
		end
	endtask

	task automatic drain_all();
		req_if.valid <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	// response checking and stall pattern
	always @(posedge clk) begin
		answer_t a;
		if (rsp_if.valid && rsp_if.ready) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d slot %0d",
						rsp_if.status, rsp_if.slot);
			end else begin
				a = pending_answers.pop_front();
				if (rsp_if.status !== a.status || rsp_if.slot !== a.slot) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
							a.status, a.slot, rsp_if.status, rsp_if.slot);
				end
			end
		end
		if ($urandom_range(0, 63) == 0)
			stall_mode = $urandom_range(0, 3);
		if (hold)
			rsp_if.ready <= 1'b0;
		else case (stall_mode)
			0: rsp_if.ready <= 1'b1;
			1: rsp_if.ready <= $urandom_range(0, 3) != 0;
			2: rsp_if.ready <= 1'($urandom_range(0, 1));
			default: rsp_if.ready <= $urandom_range(0, 7) == 0;
		endcase
	end

	// long receiver hold-off while the sender keeps going
	initial begin
		hold = 1'b0;
		wait (sent_items >= 60);
		@(posedge clk);
		hold <= 1'b1;
		repeat (800) @(posedge clk);
		hold <= 1'b0;
	end

	// stimulus
	initial begin
		dir_row_t rows[$];
		int       r;
		int       h;
		for (r = 0; r < NSLOT; r++) begin
			slot_used[r] = 1'b0;
			slot_link[r] = NULL_LNK;
			slot_key[r]  = '0;
			slot_data[r] = '0;
		end
		live_count         = 0;
		mismatches         = 0;
		sent_items         = 0;
		stall_mode         = 0;
		burst_left         = 5;
		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.kind        = KIND_INSERT;
		req_if.phone_key   = '0;
		req_if.record_data = '0;
		rsp_if.ready       = 1'b0;

		// directed cases: empty, extremes, collisions, head and middle removal
		rows = '{
			'{KIND_WITHDRAW, 40'd5, 32'd0, 1'b1, STAT_EMPTY, 10'd0},
			'{KIND_INSERT, 40'd0, 32'd0, 1'b1, STAT_OK, 10'd0},
			'{KIND_INSERT, 40'd999999999999, 32'hffffffff, 1'b1, STAT_OK, 10'd999},
			'{KIND_INSERT, 40'd1000, 32'h12345678, 1'b1, STAT_OK, 10'd1},
			'{KIND_INSERT, 40'd2000, 32'h0, 1'b0, STAT_OK, 10'd0},
			'{KIND_WITHDRAW, 40'd3000, 32'h0, 1'b1, STAT_MISSING, 10'd0},
			'{KIND_WITHDRAW, 40'd1000, 32'h0, 1'b0, STAT_OK, 10'd0},
			'{KIND_WITHDRAW, 40'd0, 32'h0, 1'b0, STAT_OK, 10'd0},
			'{KIND_WITHDRAW, 40'd2000, 32'h0, 1'b0, STAT_OK, 10'd0},
			'{KIND_INSERT, 40'd1999, 32'haaaaaaaa, 1'b0, STAT_OK, 10'd0},
			'{KIND_INSERT, 40'd5999, 32'h55555555, 1'b0, STAT_OK, 10'd0},
			'{KIND_WITHDRAW, 40'd999999999999, 32'h0, 1'b0, STAT_OK, 10'd0},
			'{KIND_WITHDRAW, 40'd999999999999, 32'h0, 1'b0, STAT_OK, 10'd0},
			'{KIND_INSERT, 40'hffffffffff, 32'h0, 1'b1, STAT_OK, 10'd775},
			'{KIND_WITHDRAW, 40'hffffffffff, 32'h0, 1'b1, STAT_OK, 10'd775},
			'{KIND_INSERT, 40'd42, 32'd1, 1'b0, STAT_OK, 10'd0},
			'{KIND_INSERT, 40'd42, 32'd2, 1'b0, STAT_OK, 10'd0},
			'{KIND_WITHDRAW, 40'd42, 32'h0, 1'b0, STAT_OK, 10'd0},
			'{KIND_WITHDRAW, 40'd42, 32'h0, 1'b0, STAT_OK, 10'd0},
			'{KIND_WITHDRAW, 40'd42, 32'h0, 1'b0, STAT_OK, 10'd0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			offer(rows[i].kind, rows[i].key, rows[i].data, rows[i].fixed,
				rows[i].exp_status, rows[i].exp_slot);

		// random mix with chains on a few home slots
		offer_mixed(60);
		drain_all();

		// fill every home slot, then push past the full limit
		for (h = 0; h < 1000; h++)
			offer(KIND_INSERT, phone_of(h), $urandom, 1'b0, STAT_OK, '0);
		for (h = 0; h < 40; h++)
			offer(KIND_INSERT, phone_of($urandom_range(0, 999)), $urandom,
				1'b0, STAT_OK, '0);
		drain_all();

		// empty out part of the table with stale links around
		offer_mixed(30);

		req_if.valid <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
